/* rtl/core/lwc_pkg.sv */
// ---------------------------------------------------------------------------
// lwc_pkg: shared definitions for the column width cache
// Sizes, operation and status codes, register indexes and the structs passed
// between the controller, the datapath and the top level.
// ---------------------------------------------------------------------------
package lwc_pkg;

  localparam int unsigned CACHE_ENTRIES = 128;
  localparam int unsigned KEY_BITS      = 16;
  localparam int unsigned WIDTH_BITS    = 8;
  localparam int unsigned STAMP_BITS    = 32;
  localparam int unsigned CACHE_LIMIT   = 100;
  localparam int unsigned CAPACITY      =
    (CACHE_ENTRIES < CACHE_LIMIT) ? CACHE_ENTRIES : CACHE_LIMIT;
  localparam int unsigned IDX_BITS      = $clog2(CACHE_ENTRIES);
  localparam int unsigned CNT_BITS      = $clog2(CACHE_ENTRIES + 1);
  localparam int unsigned FUNC_BITS     = 2;
  localparam int unsigned STATUS_BITS   = 2;
  localparam int unsigned CFG_IDX_BITS  = 2;

  typedef enum logic [FUNC_BITS-1:0] {
    FN_GET = 2'd0,
    FN_SET = 2'd1,
    FN_INC = 2'd2,
    FN_DEC = 2'd3
  } lwc_func_t;

  localparam logic [STATUS_BITS-1:0] ST_FOUND  = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_NO_ROW = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_ERROR  = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_UNUSED = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_WIDTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_WIDTH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEF_WIDTH = 2'd2;

  localparam logic [WIDTH_BITS-1:0] MIN_WIDTH_RST = WIDTH_BITS'(1);
  localparam logic [WIDTH_BITS-1:0] MAX_WIDTH_RST = WIDTH_BITS'(255);
  localparam logic [WIDTH_BITS-1:0] DEF_WIDTH_RST = WIDTH_BITS'(10);

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [WIDTH_BITS-1:0] width;
    logic [STAMP_BITS-1:0] stamp;
  } lwc_rec_t;

  typedef struct packed {
    logic [FUNC_BITS-1:0]   func;
    logic [KEY_BITS-1:0]    column;
    logic [WIDTH_BITS-1:0]  new_width;
    logic [WIDTH_BITS-1:0]  fetched_width;
    logic [STATUS_BITS-1:0] fetch_status;
  } lwc_item_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] width_out;
    logic                  hit;
    logic                  store_write;
    logic [KEY_BITS-1:0]   store_column;
    logic [WIDTH_BITS-1:0] store_width;
  } lwc_res_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } lwc_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } lwc_sts_t;

endpackage

/* rtl/core/lwc_in_if.sv */
// ---------------------------------------------------------------------------
// lwc_in_if: request channel
// One operation on a column together with the backing store's answer.
// ---------------------------------------------------------------------------
interface lwc_in_if;
  import lwc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FUNC_BITS-1:0]   func;
  logic [KEY_BITS-1:0]    column;
  logic [WIDTH_BITS-1:0]  new_width;
  logic [WIDTH_BITS-1:0]  fetched_width;
  logic [STATUS_BITS-1:0] fetch_status;

  modport source (
    output valid, func, column, new_width, fetched_width, fetch_status,
    input  ready
  );

  modport sink (
    input  valid, func, column, new_width, fetched_width, fetch_status,
    output ready
  );
endinterface

/* rtl/core/lwc_out_if.sv */
// ---------------------------------------------------------------------------
// lwc_out_if: result channel
// Returned width, hit flag and the write-through request.
// ---------------------------------------------------------------------------
interface lwc_out_if;
  import lwc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [WIDTH_BITS-1:0] width_out;
  logic                  hit;
  logic                  store_write;
  logic [KEY_BITS-1:0]   store_column;
  logic [WIDTH_BITS-1:0] store_width;

  modport source (
    output valid, width_out, hit, store_write, store_column, store_width,
    input  ready
  );

  modport sink (
    input  valid, width_out, hit, store_write, store_column, store_width,
    output ready
  );
endinterface

/* rtl/core/lru_width_cache.sv */
// ---------------------------------------------------------------------------
// lru_width_cache: fully associative LRU cache of column widths
// Write-through width cache in front of a backing store, one result per request.
// ---------------------------------------------------------------------------
// Each request passes through acceptance, a scan of every entry through the
// single read port of the entry memory with its registered read data and a
// completion check, and a final step, held until the result register is
// free, that writes the entry back and loads the result register. A new
// request may be taken while the previous result still waits on the result
// channel. Entry valid bits sit in flip-flops and clear on reset, so no
// clearing pass runs. Configuration writes are applied at once and must only
// occur while idle.
module lru_width_cache (
  input  logic                             clk,
  input  logic                             rst_n,
  lwc_in_if.sink                           in_ch,
  lwc_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [lwc_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [lwc_pkg::WIDTH_BITS-1:0]   cfg_data
);
  import lwc_pkg::*;

  lwc_cmd_t  cmd;
  lwc_sts_t  sts;
  lwc_item_t item;
  lwc_res_t  res;
  logic      res_valid;
  logic      in_ready;

  assign item.func          = in_ch.func;
  assign item.column        = in_ch.column;
  assign item.new_width     = in_ch.new_width;
  assign item.fetched_width = in_ch.fetched_width;
  assign item.fetch_status  = in_ch.fetch_status;
  assign in_ch.ready        = in_ready;

  lwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lwc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .item      (item),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (out_ch.ready),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  assign out_ch.valid        = res_valid;
  assign out_ch.width_out    = res.width_out;
  assign out_ch.hit          = res.hit;
  assign out_ch.store_write  = res.store_write;
  assign out_ch.store_column = res.store_column;
  assign out_ch.store_width  = res.store_width;

endmodule

/* rtl/core/lwc_ram.sv */
// ---------------------------------------------------------------------------
// lwc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module lwc_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/lwc_datapath.sv */
// ---------------------------------------------------------------------------
// lwc_datapath: entry store, scan accumulators and result register
// Scans every entry for the key, the first free slot and the oldest stamp,
// then writes back at most one entry and registers the result.
// ---------------------------------------------------------------------------
module lwc_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lwc_pkg::lwc_cmd_t                  cmd,
  output lwc_pkg::lwc_sts_t                  sts,
  input  lwc_pkg::lwc_item_t                 item,
  output lwc_pkg::lwc_res_t                  res,
  output logic                               res_valid,
  input  logic                               res_ready,
  input  logic                               cfg_we,
  input  logic [lwc_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
  input  logic [lwc_pkg::WIDTH_BITS-1:0]     cfg_data
);
  import lwc_pkg::*;

  localparam logic [IDX_BITS:0] SCAN_END = (IDX_BITS + 1)'(CACHE_ENTRIES);

  lwc_item_t              item_r;
  logic [IDX_BITS:0]      scan_cnt_r;
  logic                   rd_vld_r;
  logic [IDX_BITS-1:0]    rd_idx_r;
  logic [CACHE_ENTRIES-1:0] valid_r;
  logic [STAMP_BITS-1:0]  stamp_ctr_r;
  logic [WIDTH_BITS-1:0]  min_r;
  logic [WIDTH_BITS-1:0]  max_r;
  logic [WIDTH_BITS-1:0]  def_r;

  logic                   hit_found_r;
  logic [IDX_BITS-1:0]    hit_idx_r;
  logic [WIDTH_BITS-1:0]  hit_width_r;
  logic [STAMP_BITS-1:0]  hit_stamp_r;
  logic [CNT_BITS-1:0]    used_r;
  logic                   free_found_r;
  logic [IDX_BITS-1:0]    free_idx_r;
  logic                   old_found_r;
  logic [IDX_BITS-1:0]    old_idx_r;
  logic [STAMP_BITS-1:0]  old_stamp_r;
  logic [KEY_BITS-1:0]    old_key_r;

  lwc_res_t               res_r;
  logic                   res_valid_r;

  logic                   rd_en;
  lwc_rec_t               rd_rec;
  logic                   rd_live;

  logic                   err;
  logic                   need_evict;
  logic                   ins;
  logic [WIDTH_BITS-1:0]  g;
  logic [WIDTH_BITS:0]    cand;
  logic                   neg;
  logic                   accept;
  logic                   store;
  logic                   wr_en;
  logic                   bump;
  logic [IDX_BITS-1:0]    wr_slot;
  lwc_rec_t               wr_rec;
  lwc_res_t               res_nxt;

  assign rd_en   = cmd.scan && (scan_cnt_r != SCAN_END);
  assign rd_live = rd_vld_r && valid_r[rd_idx_r];

  lwc_ram #(
    .DATA_W ($bits(lwc_rec_t)),
    .DEPTH  (CACHE_ENTRIES)
  ) u_entries (
    .clk   (clk),
    .we    (cmd.finish && wr_en),
    .waddr (wr_slot),
    .wdata (wr_rec),
    .re    (rd_en),
    .raddr (scan_cnt_r[IDX_BITS-1:0]),
    .rdata (rd_rec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_WIDTH_RST;
      max_r <= MAX_WIDTH_RST;
      def_r <= DEF_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MIN_WIDTH: min_r <= cfg_data;
        CFG_MAX_WIDTH: max_r <= cfg_data;
        CFG_DEF_WIDTH: def_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item_r <= item;
    end
    if (rd_en) begin
      rd_idx_r <= scan_cnt_r[IDX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r   <= '0;
      rd_vld_r     <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      old_found_r  <= 1'b0;
      used_r       <= '0;
    end else if (cmd.start) begin
      scan_cnt_r   <= '0;
      rd_vld_r     <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      old_found_r  <= 1'b0;
      used_r       <= '0;
    end else begin
      rd_vld_r <= rd_en;
      if (rd_en) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
      if (rd_vld_r) begin
        if (rd_live) begin
          used_r <= used_r + 1'b1;
        end else if (!free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= rd_idx_r;
        end
        if (rd_live && !hit_found_r && (rd_rec.key == item_r.column)) begin
          hit_found_r <= 1'b1;
          hit_idx_r   <= rd_idx_r;
          hit_width_r <= rd_rec.width;
          hit_stamp_r <= rd_rec.stamp;
        end
        if (rd_live && (!old_found_r || (rd_rec.stamp < old_stamp_r) ||
            ((rd_rec.stamp == old_stamp_r) && (rd_rec.key < old_key_r)))) begin
          old_found_r <= 1'b1;
          old_idx_r   <= rd_idx_r;
          old_stamp_r <= rd_rec.stamp;
          old_key_r   <= rd_rec.key;
        end
      end
    end
  end

  always_comb begin
    err        = item_r.fetch_status inside {ST_ERROR, ST_UNUSED};
    g          = hit_found_r ? hit_width_r :
                 ((item_r.fetch_status == ST_FOUND) ? item_r.fetched_width : def_r);
    need_evict = (used_r >= CNT_BITS'(CAPACITY)) || !free_found_r;
    ins        = !hit_found_r && !err && (!need_evict || old_found_r);
    wr_slot    = hit_found_r ? hit_idx_r : (need_evict ? old_idx_r : free_idx_r);

    neg  = 1'b0;
    cand = {1'b0, item_r.new_width};
    case (lwc_func_t'(item_r.func))
      FN_INC: cand = {1'b0, g} + 1'b1;
      FN_DEC: begin
        neg  = (g == '0);
        cand = {1'b0, g} - 1'b1;
      end
      default: cand = {1'b0, item_r.new_width};
    endcase
    accept = !neg && (cand >= {1'b0, min_r}) && (cand <= {1'b0, max_r});
    store  = accept && (lwc_func_t'(item_r.func) != FN_GET);

    wr_rec.key   = item_r.column;
    wr_rec.width = g;
    wr_rec.stamp = stamp_ctr_r + 1'b1;
    wr_en        = hit_found_r || ins;
    bump         = wr_en;

    res_nxt.hit          = hit_found_r;
    res_nxt.store_write  = store;
    res_nxt.store_column = store ? item_r.column : '0;
    res_nxt.store_width  = store ? cand[WIDTH_BITS-1:0] : '0;
    res_nxt.width_out    = g;

    case (lwc_func_t'(item_r.func))
      FN_GET: ;
      FN_SET: begin
        wr_en             = hit_found_r && accept;
        bump              = 1'b0;
        wr_rec.width      = cand[WIDTH_BITS-1:0];
        wr_rec.stamp      = hit_stamp_r;
        res_nxt.width_out = accept ? item_r.new_width : '0;
      end
      FN_INC, FN_DEC: begin
        wr_rec.width      = accept ? cand[WIDTH_BITS-1:0] : g;
        res_nxt.width_out = accept ? cand[WIDTH_BITS-1:0] : g;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      stamp_ctr_r <= '0;
    end else if (cmd.finish) begin
      if (wr_en) begin
        valid_r[wr_slot] <= 1'b1;
      end
      if (bump) begin
        stamp_ctr_r <= stamp_ctr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_r <= res_nxt;
    end
  end

  assign sts.scan_done = (scan_cnt_r == SCAN_END) && !rd_vld_r;
  assign sts.out_free  = !res_valid_r || res_ready;
  assign res           = res_r;
  assign res_valid     = res_valid_r;

`ifndef SYNTHESIS
  a_finish_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.scan_done)
    else $error("finish issued before the scan completed");

  a_read_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(cmd.scan))
    else $error("read data flagged without a scan step");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_BITS'(CACHE_ENTRIES))
    else $error("used count exceeds the entry count");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && wr_en) |=> valid_r[$past(wr_slot)])
    else $error("written entry not marked valid");
`endif

endmodule

/* rtl/core/lwc_ctrl.sv */
// ---------------------------------------------------------------------------
// lwc_ctrl: sequencer for the column width cache
// Accepts one request, runs the entry scan, then issues write-back and
// result load once the result register is free.
// ---------------------------------------------------------------------------
module lwc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lwc_pkg::lwc_sts_t sts,
  output lwc_pkg::lwc_cmd_t cmd
);
  import lwc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r    <= S_SCAN;
            in_ready_r <= 1'b0;
          end
        end
        S_SCAN: begin
          if (sts.scan_done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (sts.out_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready   = in_ready_r;
  assign cmd.start  = in_valid && in_ready_r;
  assign cmd.scan   = (state_r == S_SCAN);
  assign cmd.finish = (state_r == S_FIN) && sts.out_free;

endmodule
